// File: rtl/klk_pkg.sv
// Package for the keypad code lock: sizes, codes and item/result types.
package klk_pkg;

    localparam int KEY_COUNT   = 8;
    localparam int CODE_DIGITS = 4;

    localparam int KEY_W    = 8;
    localparam int KNUM_W   = 4;
    localparam int CODE_W   = 16;
    localparam int THR_W    = 4;
    localparam int COUNT_W  = 3;
    localparam int FAIL_W   = 4;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [KEY_W-1:0]   KEY_MASK   = KEY_W'((1 << KEY_COUNT) - 1);
    localparam int                 CMP_BITS   = (4 * CODE_DIGITS >= CODE_W) ?
                                                CODE_W : 4 * CODE_DIGITS;
    localparam logic [CODE_W-1:0]  DIGIT_MASK = CODE_W'((64'd1 << CMP_BITS) - 64'd1);
    localparam logic [COUNT_W-1:0] DIGITS_FULL = COUNT_W'(CODE_DIGITS);
    localparam logic [FAIL_W-1:0]  FAIL_MAX    = '1;

    localparam logic [CODE_W-1:0] CODE_RESET = 16'h1234;
    localparam logic [THR_W-1:0]  THR_RESET  = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_WORD = 1'b0,
        CFG_ALARM_THR = 1'b1
    } klk_cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NORMAL = 2'd3
    } klk_mode_t;

    typedef enum logic [1:0] {
        CHECK_NONE  = 2'd0,
        CHECK_MATCH = 2'd1,
        CHECK_WRONG = 2'd2
    } klk_check_t;

    typedef enum logic [1:0] {
        BEEP_NONE    = 2'd0,
        BEEP_CLICK   = 2'd1,
        BEEP_SUCCESS = 2'd2,
        BEEP_FAILURE = 2'd3
    } klk_beep_t;

    localparam logic [KNUM_W-1:0] KEY_ADD    = KNUM_W'(MODE_ADD);
    localparam logic [KNUM_W-1:0] KEY_DELETE = KNUM_W'(MODE_DELETE);
    localparam logic [KNUM_W-1:0] KEY_LEAVE  = KNUM_W'(MODE_NORMAL);

    typedef struct packed {
        logic [KEY_W-1:0] key_sample;
        logic             card_accepted;
        logic             admin_active;
    } klk_item_t;

    typedef struct packed {
        logic [KNUM_W-1:0]  key_taken;
        klk_mode_t          card_mode_request;
        logic               admin_leave;
        logic               admin_screen_clear;
        logic [COUNT_W-1:0] digits_entered;
        klk_check_t         check_outcome;
        logic               alarm_raise;
        logic               alarm_clear;
        logic [FAIL_W-1:0]  fail_total;
        klk_beep_t          beep_kind;
    } klk_result_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [THR_W-1:0]  alarm_threshold;
    } klk_cfg_t;

endpackage

// File: rtl/klk_in_reg.sv
// Input register: holds one request until the core takes it.
module klk_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  klk_pkg::klk_item_t item_in,
    input  logic              advance,
    output logic              item_valid,
    output klk_pkg::klk_item_t item
);
    import klk_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    klk_item_t item_reg;
    logic      take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// File: rtl/klk_core.sv
// Lock core: key decode, digit collection, code check and lock state.
module klk_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  klk_pkg::klk_item_t  item,
    input  klk_pkg::klk_cfg_t   cfg,
    output klk_pkg::klk_result_t result
);
    import klk_pkg::*;

    logic               hold_reg,   hold_next;
    logic [CODE_W-1:0]  digits_reg, digits_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [FAIL_W-1:0]  fail_reg,   fail_next;

    logic [KEY_W-1:0]   keys;
    logic               unlocked;
    logic               released;
    logic               press;
    logic [KNUM_W-1:0]  key_num;
    logic [CODE_W-1:0]  digits_col;
    logic [COUNT_W-1:0] count_col;
    logic               check;
    logic               match;
    logic [FAIL_W-1:0]  fail_inc;

    // lowest pressed key wins: scan from the top, last hit stays
    always_comb
    begin
        key_num = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--)
        begin
            if (!keys[i])
            begin
                key_num = KNUM_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        keys     = item.key_sample & KEY_MASK;
        unlocked = item.card_accepted || item.admin_active;
        released = (keys == KEY_MASK);
        press    = unlocked && !released && !hold_reg;

        if (press && !item.admin_active)
        begin
            digits_col = {digits_reg[CODE_W-5:0], key_num};
            count_col  = count_reg + COUNT_W'(1);
        end
        else
        begin
            digits_col = digits_reg;
            count_col  = count_reg;
        end

        check    = press && (count_col >= DIGITS_FULL);
        match    = ((digits_col ^ cfg.code_word) & DIGIT_MASK) == '0;
        fail_inc = (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + FAIL_W'(1);

        hold_next   = hold_reg;
        digits_next = digits_col;
        count_next  = count_col;
        fail_next   = fail_reg;

        result                    = '0;
        result.card_mode_request  = MODE_NONE;
        result.check_outcome      = CHECK_NONE;
        result.beep_kind          = BEEP_NONE;
        result.digits_entered     = count_col;

        if (unlocked && released)
        begin
            hold_next = 1'b0;
        end

        if (press)
        begin
            hold_next        = 1'b1;
            result.key_taken = key_num;
            result.beep_kind = BEEP_CLICK;
            if (item.admin_active &&
                (key_num == KEY_ADD || key_num == KEY_DELETE || key_num == KEY_LEAVE))
            begin
                result.card_mode_request  = klk_mode_t'(key_num[1:0]);
                result.admin_screen_clear = 1'b1;
                result.admin_leave        = (key_num == KEY_LEAVE);
            end
        end

        if (check)
        begin
            digits_next = '0;
            count_next  = '0;
            if (match)
            begin
                fail_next            = '0;
                result.check_outcome = CHECK_MATCH;
                result.alarm_clear   = 1'b1;
                result.beep_kind     = BEEP_SUCCESS;
            end
            else
            begin
                fail_next            = fail_inc;
                result.check_outcome = CHECK_WRONG;
                result.beep_kind     = BEEP_FAILURE;
                result.alarm_raise   = (fail_inc >= cfg.alarm_threshold);
            end
        end

        result.fail_total = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b0;
            digits_reg <= '0;
            count_reg  <= '0;
            fail_reg   <= '0;
        end
        else if (fire)
        begin
            hold_reg   <= hold_next;
            digits_reg <= digits_next;
            count_reg  <= count_next;
            fail_reg   <= fail_next;
        end
    end

endmodule

// File: rtl/klk_out_reg.sv
// Result register: holds a result until the far side takes it.
module klk_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  klk_pkg::klk_result_t result_in,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output klk_pkg::klk_result_t result
);
    import klk_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    klk_result_t result_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign result     = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// File: rtl/keypad_code_lock.sv
// Top level of the keypad code lock: config registers and the request pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | to lock   | in_valid / in_stall  | key_sample, card_accepted, admin_active
//  out     | from lock | out_valid / out_stall| key_taken ... beep_kind (one per request)
//  cfg     | to lock   | cfg_we               | cfg_index, cfg_wdata
//
// One request a cycle when the output side keeps up; each request passes
// through the input register, then the result register. The key decode,
// digit shift, code compare and fail count update sit in one combinational
// pass between the two registers, and the lock state moves on as the result
// is written. Reset clears the lock state, both valid flags, and loads the
// code 0x1234 with alarm threshold 3. A stall on the output holds the result
// and, once the input register is full too, stalls the input.
module keypad_code_lock (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [klk_pkg::KEY_W-1:0]     key_sample,
    input  logic                          card_accepted,
    input  logic                          admin_active,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [klk_pkg::KNUM_W-1:0]    key_taken,
    output logic [1:0]                    card_mode_request,
    output logic                          admin_leave,
    output logic                          admin_screen_clear,
    output logic [klk_pkg::COUNT_W-1:0]   digits_entered,
    output logic [1:0]                    check_outcome,
    output logic                          alarm_raise,
    output logic                          alarm_clear,
    output logic [klk_pkg::FAIL_W-1:0]    fail_total,
    output logic [1:0]                    beep_kind,
    // configuration
    input  logic                          cfg_we,
    input  logic [klk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [klk_pkg::CFG_W-1:0]     cfg_wdata
);
    import klk_pkg::*;

    klk_cfg_t    cfg_reg;
    klk_cfg_t    cfg_next;
    klk_item_t   item_in;
    klk_item_t   item;
    logic        item_valid;
    logic        out_free;
    logic        fire;
    klk_result_t core_result;
    klk_result_t result;

    // decode the register index; codes outside the list change nothing
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (klk_cfg_idx_t'(cfg_index))
                CFG_CODE_WORD: cfg_next.code_word       = cfg_wdata[CODE_W-1:0];
                CFG_ALARM_THR: cfg_next.alarm_threshold = cfg_wdata[THR_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_word       <= CODE_RESET;
            cfg_reg.alarm_threshold <= THR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item_in.key_sample    = key_sample;
    assign item_in.card_accepted = card_accepted;
    assign item_in.admin_active  = admin_active;

    // advance the held request whenever the result register has room
    assign fire = item_valid && out_free;

    klk_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    klk_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    klk_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result_in (core_result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign key_taken          = result.key_taken;
    assign card_mode_request  = result.card_mode_request;
    assign admin_leave        = result.admin_leave;
    assign admin_screen_clear = result.admin_screen_clear;
    assign digits_entered     = result.digits_entered;
    assign check_outcome      = result.check_outcome;
    assign alarm_raise        = result.alarm_raise;
    assign alarm_clear        = result.alarm_clear;
    assign fail_total         = result.fail_total;
    assign beep_kind          = result.beep_kind;

endmodule

// File: rtl/klk_checker.sv
// Port checker for the keypad code lock, bound to the top level.
module klk_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [klk_pkg::KNUM_W-1:0]    key_taken,
    input logic [1:0]                    card_mode_request,
    input logic                          admin_leave,
    input logic [klk_pkg::COUNT_W-1:0]   digits_entered,
    input logic [1:0]                    check_outcome,
    input logic                          alarm_clear,
    input logic [klk_pkg::FAIL_W-1:0]    fail_total,
    input logic [1:0]                    beep_kind
);
    import klk_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fail_total) && $stable(beep_kind))
        else $error("result changed while stalled");

    // a match clears the fail count, sounds success, clears the alarm and shows a full digit count
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && check_outcome == CHECK_MATCH |->
        fail_total == '0 && alarm_clear && beep_kind == BEEP_SUCCESS &&
        digits_entered == DIGITS_FULL)
        else $error("match result inconsistent");

    // no key taken means no beep, no check and no mode request
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_taken == '0 |->
        beep_kind == BEEP_NONE && check_outcome == CHECK_NONE &&
        card_mode_request == MODE_NONE)
        else $error("effect without a key");

    // leaving admin mode goes only with the normal-mode request and no code check
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && admin_leave |-> card_mode_request == MODE_NORMAL &&
        check_outcome == CHECK_NONE)
        else $error("admin leave without normal request");

endmodule

bind keypad_code_lock klk_checker u_klk_checker (.*);

// File: bench/klk_lock_check_pkg.sv
// Result predictor and in-order checker for the keypad code lock bench.
package klk_lock_check_pkg;

    import klk_pkg::*;

    class code_lock_checker;

        logic [CODE_W-1:0]  code_word;
        logic [THR_W-1:0]   alarm_threshold;
        bit                 key_held;
        logic [CODE_W-1:0]  digit_shift;
        logic [COUNT_W-1:0] digit_count;
        logic [FAIL_W-1:0]  fail_count;

        klk_result_t        due_results[$];
        int                 faults;

        function new();
            code_word       = CODE_RESET;
            alarm_threshold = THR_RESET;
            key_held        = 1'b0;
            digit_shift     = '0;
            digit_count     = '0;
            fail_count      = '0;
            faults          = 0;
        endfunction

        function void set_register(klk_cfg_idx_t idx, logic [CFG_W-1:0] value);
            if (idx == CFG_CODE_WORD)
                code_word = value[CODE_W-1:0];
            else
                alarm_threshold = value[THR_W-1:0];
        endfunction

        // Work out the result of one accepted request and queue it.
        function void predict_request(klk_item_t req);
            klk_result_t        res;
            logic [KEY_W-1:0]   keys;
            logic [KNUM_W-1:0]  key;
            res  = '0;
            keys = req.key_sample & KEY_MASK;
            key  = '0;
            if (!(req.card_accepted || req.admin_active)) begin
                // locked: state kept
            end
            else if (keys == KEY_MASK) begin
                key_held = 1'b0;
            end
            else if (!key_held) begin
                key_held = 1'b1;
                for (int i = KEY_COUNT - 1; i >= 0; i--)
                    if (!keys[i])
                        key = KNUM_W'(i + 1);
                res.key_taken = key;
                res.beep_kind = BEEP_CLICK;
                if (req.admin_active) begin
                    if (key >= KEY_ADD && key <= KEY_LEAVE) begin
                        res.card_mode_request  = klk_mode_t'(key[1:0]);
                        res.admin_screen_clear = 1'b1;
                        res.admin_leave        = (key == KEY_LEAVE);
                    end
                end
                else begin
                    digit_shift = {digit_shift[CODE_W-5:0], key};
                    digit_count = digit_count + 1'b1;
                end
                res.digits_entered = digit_count;
                if (digit_count >= DIGITS_FULL) begin
                    if ((digit_shift & DIGIT_MASK) == (code_word & DIGIT_MASK)) begin
                        fail_count        = '0;
                        res.check_outcome = CHECK_MATCH;
                        res.alarm_clear   = 1'b1;
                        res.beep_kind     = BEEP_SUCCESS;
                    end
                    else begin
                        if (fail_count != FAIL_MAX)
                            fail_count = fail_count + 1'b1;
                        res.check_outcome = CHECK_WRONG;
                        res.beep_kind     = BEEP_FAILURE;
                        res.alarm_raise   = (fail_count >= alarm_threshold);
                    end
                    digit_shift = '0;
                    digit_count = '0;
                end
            end
            if (res.key_taken == '0)
                res.digits_entered = digit_count;
            res.fail_total = fail_count;
            due_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest queued one.
        function void check_result(klk_result_t got);
            klk_result_t exp;
            string       bad;
            bad = "";
            if (due_results.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result %h with no request pending", got);
                return;
            end
            exp = due_results.pop_front();
            if (got.key_taken !== exp.key_taken)                   bad = {bad, " key_taken"};
            if (got.card_mode_request !== exp.card_mode_request)   bad = {bad, " card_mode_request"};
            if (got.admin_leave !== exp.admin_leave)               bad = {bad, " admin_leave"};
            if (got.admin_screen_clear !== exp.admin_screen_clear) bad = {bad, " admin_screen_clear"};
            if (got.digits_entered !== exp.digits_entered)         bad = {bad, " digits_entered"};
            if (got.check_outcome !== exp.check_outcome)           bad = {bad, " check_outcome"};
            if (got.alarm_raise !== exp.alarm_raise)               bad = {bad, " alarm_raise"};
            if (got.alarm_clear !== exp.alarm_clear)               bad = {bad, " alarm_clear"};
            if (got.fail_total !== exp.fail_total)                 bad = {bad, " fail_total"};
            if (got.beep_kind !== exp.beep_kind)                   bad = {bad, " beep_kind"};
            if (bad != "") begin
                faults++;
                if (faults <= 10)
                    $display("result mismatch on%s: expected %h got %h", bad, exp, got);
            end
        endfunction

    endclass

endpackage

// File: bench/keypad_code_lock_test.sv
// Self-checking bench for the keypad code lock: directed and random requests.
module keypad_code_lock_test;

    timeunit 1ns;
    timeprecision 1ps;

    import klk_pkg::*;
    import klk_lock_check_pkg::*;

    // Clock, reset and every block input start at known values.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [KEY_W-1:0]     key_sample = '1;
    logic                 card_accepted = 1'b0;
    logic                 admin_active = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KNUM_W-1:0]    key_taken;
    logic [1:0]           card_mode_request;
    logic                 admin_leave;
    logic                 admin_screen_clear;
    logic [COUNT_W-1:0]   digits_entered;
    logic [1:0]           check_outcome;
    logic                 alarm_raise;
    logic                 alarm_clear;
    logic [FAIL_W-1:0]    fail_total;
    logic [1:0]           beep_kind;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CODE_WORD;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    code_lock_checker     lock_check;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   request_count = 0;
    logic [CODE_W-1:0]    current_code = CODE_RESET;

    keypad_code_lock i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .key_sample         (key_sample),
        .card_accepted      (card_accepted),
        .admin_active       (admin_active),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .key_taken          (key_taken),
        .card_mode_request  (card_mode_request),
        .admin_leave        (admin_leave),
        .admin_screen_clear (admin_screen_clear),
        .digits_entered     (digits_entered),
        .check_outcome      (check_outcome),
        .alarm_raise        (alarm_raise),
        .alarm_clear        (alarm_clear),
        .fail_total         (fail_total),
        .beep_kind          (beep_kind),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Receiver: stall at random at the current rate, driven at the edge so
    // the block sees a settled value for the whole cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Result monitor: values read here are those from before the edge, so a
    // result counts exactly when valid was high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            lock_check.check_result('{
                key_taken:          key_taken,
                card_mode_request:  klk_mode_t'(card_mode_request),
                admin_leave:        admin_leave,
                admin_screen_clear: admin_screen_clear,
                digits_entered:     digits_entered,
                check_outcome:      klk_check_t'(check_outcome),
                alarm_raise:        alarm_raise,
                alarm_clear:        alarm_clear,
                fail_total:         fail_total,
                beep_kind:          klk_beep_t'(beep_kind)
            });
    end

    // Present one request and hold it until the lock takes it. An optional
    // idle gap comes first; valid is only lowered when a gap is taken, so it
    // never gets two assignments in one step.
    task automatic send_request(logic [KEY_W-1:0] keys, logic card, logic admin);
        klk_item_t req;
        req = '{key_sample: keys, card_accepted: card, admin_active: admin};
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        key_sample    <= keys;
        card_accepted <= card;
        admin_active  <= admin;
        do
            @(posedge clk);
        while (in_stall);
        lock_check.predict_request(req);
        // locked requests are merely ignored; leave them out of the budget
        if (card || admin)
            request_count++;
    endtask

    // Drop valid and hold off until every queued result is back, then let
    // the two-stage pipeline settle a little longer.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (lock_check.due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back; only called with the lock idle.
    task automatic write_settings(logic [CODE_W-1:0] code, logic [THR_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CODE_WORD;
        cfg_wdata <= CFG_W'(code);
        @(posedge clk);
        cfg_index <= CFG_ALARM_THR;
        cfg_wdata <= CFG_W'(thr);
        @(posedge clk);
        cfg_we <= 1'b0;
        lock_check.set_register(CFG_CODE_WORD, CFG_W'(code));
        lock_check.set_register(CFG_ALARM_THR, CFG_W'(thr));
        current_code = code;
    endtask

    // Scan word whose lowest pressed key is the given one; keys above it
    // are random so every bit sees both levels.
    function automatic logic [KEY_W-1:0] press_word(int unsigned key);
        logic [KEY_W-1:0] w;
        w = KEY_W'($urandom);
        w = w | KEY_W'((1 << (key - 1)) - 1);
        w[key-1] = 1'b0;
        return w;
    endfunction

    // Press, sometimes a held scan with more keys down, then release.
    task automatic key_stroke(logic [KEY_W-1:0] press, logic card, logic admin);
        send_request(press, card, admin);
        if ($urandom_range(0, 3) == 0)
            send_request(press & KEY_W'($urandom), card, admin);
        send_request('1, card, admin);
    endtask

    // Key in a full code with a card present: either the stored code, where
    // its digits can be keyed at all, or random digits.
    task automatic enter_code(bit use_stored);
        int unsigned digit;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            digit = (current_code >> (4 * (CODE_DIGITS - 1 - i))) & 4'hF;
            if (!use_stored || digit < 1 || digit > KEY_COUNT)
                digit = $urandom_range(1, KEY_COUNT);
            key_stroke(press_word(digit), 1'b1, 1'b0);
        end
    endtask

    // One random burst: mostly well-formed code entries, then admin keys,
    // locked noise, broken single scans and the odd full pause.
    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            enter_code($urandom_range(0, 99) < 40);
        else if (pick < 75)
            key_stroke(press_word($urandom_range(1, KEY_COUNT)),
                       1'($urandom_range(0, 1)), 1'b1);
        else if (pick < 85)
            send_request(KEY_W'($urandom), 1'b0, 1'b0);
        else if (pick < 98)
            send_request(KEY_W'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        else
            wait_idle();
    endtask

    task automatic run_phase(logic [CODE_W-1:0] code, logic [THR_W-1:0] thr,
                             int send_pct, int recv_pct, int budget);
        wait_idle();
        write_settings(code, thr);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        request_count = 0;
        while (request_count < budget)
            random_burst();
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] c;
        for (int i = 0; i < CODE_DIGITS; i++)
            c[4*i +: 4] = 4'($urandom_range(1, KEY_COUNT));
        return c;
    endfunction

    initial
    begin
        lock_check = new();
        send_idle_pct = 29;
        recv_idle_pct = 49;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset settings (code 1234, threshold 3).
        send_request(8'h00, 1'b0, 1'b0);    // locked: no card, no admin
        send_request(8'hFF, 1'b1, 1'b0);    // release
        send_request(8'hFE, 1'b1, 1'b0);    // key 1
        send_request(8'hFC, 1'b1, 1'b0);    // still held: ignored
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hFD, 1'b1, 1'b0);    // key 2
        send_request(8'h00, 1'b1, 1'b0);    // every key down while held
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hFB, 1'b1, 1'b0);    // key 3
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hF7, 1'b1, 1'b0);    // key 4: code matches
        send_request(8'hFF, 1'b1, 1'b0);
        for (int i = 0; i < CODE_DIGITS; i++) begin
            send_request(8'h7F, 1'b1, 1'b0);  // key 8 four times: wrong code
            send_request(8'hFF, 1'b1, 1'b0);
        end
        send_request(8'h00, 1'b0, 1'b1);    // admin: all down, key 1 is add
        send_request(8'hFF, 1'b0, 1'b1);
        send_request(8'hFD, 1'b1, 1'b1);    // admin wins over card: delete
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'hFB, 1'b0, 1'b1);    // leave admin mode
        send_request(8'hFF, 1'b0, 1'b1);
        send_request(8'hEF, 1'b0, 1'b1);    // admin key 5: click only

        // Random phases. A zero code cannot be keyed, so the fail count
        // saturates there; a zero threshold alarms on every miss.
        run_phase(16'h0000, 4'd15, 29, 49, 180);
        run_phase(random_code(), 4'd1, 49, 29, 90);
        run_phase(16'hFFFF, 4'd0, 0, 0, 50);
        run_phase(random_code(), 4'($urandom_range(1, 15)), 0, 0, 50);

        wait_idle();
        if (lock_check.faults == 0 && lock_check.due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #200000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/klk_pkg.sv
rtl/klk_in_reg.sv
rtl/klk_core.sv
rtl/klk_out_reg.sv
rtl/keypad_code_lock.sv
rtl/klk_checker.sv
bench/klk_lock_check_pkg.sv
bench/keypad_code_lock_test.sv
